// ----- rtl/prj_pkg.sv -----
// Shared constants, types and the coordinate jitter function of the resampler.
`timescale 1ns / 1ps
`default_nettype none
package prj_pkg;

    localparam int MAX_PARTICLES = 64;
    localparam int COORD_W       = 12;
    localparam int WEIGHT_W      = 16;
    localparam int IDX_W         = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);

    // fixed field widths
    localparam int SLOT_W    = 6;
    localparam int DRAW_W    = 7;
    localparam int JIT_W     = 6;
    localparam int FRAME_W   = 12;
    localparam int BOX_W     = 10;
    localparam int PCOUNT_W  = 7;
    localparam int TOTAL_W   = 22;
    localparam int ACC_W     = TOTAL_W + DRAW_W;
    localparam int PCT       = 100;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_COUNT = 3'd4;

    // item kinds
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // word layout on the streams
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 32;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_w;
        logic [FRAME_W-1:0] frame_h;
        logic [BOX_W-1:0]   box_w;
        logic [BOX_W-1:0]   box_h;
        logic [CNT_W-1:0]   count;   // effective particle count, 1..MAX_PARTICLES
    } cfg_t;

    typedef struct packed {
        logic                    op;
        logic [SLOT_W-1:0]       slot;
        logic [COORD_W-1:0]      pos_x;
        logic [COORD_W-1:0]      pos_y;
        logic [WEIGHT_W-1:0]     score;
        logic [DRAW_W-1:0]       draw;
        logic signed [JIT_W-1:0] jitter_x;
        logic signed [JIT_W-1:0] jitter_y;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]   chosen;
        logic [COORD_W-1:0] new_x;
        logic [COORD_W-1:0] new_y;
        logic               round_done;
    } out_item_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  x;
    } part_ent_t;

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } pend_ent_t;

    localparam int PART_W = $bits(part_ent_t);
    localparam int PEND_W = $bits(pend_ent_t);

    // keep the moved coordinate only if strictly inside (0, frame - box)
    function automatic logic [COORD_W-1:0] jit_coord(
        input logic [COORD_W-1:0]       base,
        input logic signed [JIT_W-1:0]  delta,
        input logic [FRAME_W-1:0]       frame,
        input logic [BOX_W-1:0]         box
    );
        logic signed [COORD_W+1:0] moved;
        logic signed [COORD_W+1:0] bound;
        moved = $signed((COORD_W + 2)'(base)) + $signed((COORD_W + 2)'(delta));
        bound = $signed((COORD_W + 2)'(frame)) - $signed((COORD_W + 2)'(box));
        if (moved > 0 && moved < bound) begin
            return moved[COORD_W-1:0];
        end
        return base;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/particle_resample_jitter.sv -----
// Top level of the particle resampler with positional jitter.
//
// Input stream (s_*): one word per item. s_tuser selects the kind: a load
// writes one particle (slot, box corner, weight) into the table and adds its
// weight to the total (slot 0 restarts it); a draw runs one roulette-wheel selection.
// Output stream (m_*): one word per draw, none per load. m_tlast marks the
// draw that closed a round; after it the pending coordinates are copied into
// the table and every weight in use becomes one.
// Configuration: cfg_we writes register cfg_idx at the clock edge; write
// only while the block is idle.
// Flow: a draw walks the particle table from entry 0 up to the picked index
// (or up to particle_count - 1 when the walk finds nothing), reading one table
// entry per cycle from the particle RAM. A draw that closes a round is followed
// by a copy sweep from the pending RAM. One item is worked on at a time;
// s_tready is high only between items.
// Reset (aresetn low, synchronous) clears the total, the draw counter and the
// output valid and loads the register defaults; table contents stay as they
// are until written. A stalled receiver holds the result word in the output
// register; the next draw waits for it only at its last step.
`timescale 1ns / 1ps
`default_nettype none
module particle_resample_jitter (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration
    input  wire logic                                cfg_we,
    input  wire logic [prj_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  wire logic [prj_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // slot[5:0], pos_x[17:6], pos_y[29:18], score[45:30], draw[52:46],
    // jitter_x[58:53], jitter_y[64:59], zero[71:65]
    input  wire logic [prj_pkg::S_TDATA_W-1:0]       s_tdata,
    // op[0]
    input  wire logic                                s_tuser,
    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // chosen[5:0], new_x[17:6], new_y[29:18], zero[31:30]
    output logic [prj_pkg::M_TDATA_W-1:0]            m_tdata,
    // round_done
    output logic                                     m_tlast
);
    import prj_pkg::*;

    logic [FRAME_W-1:0]  frame_w_reg, frame_h_reg;
    logic [BOX_W-1:0]    box_w_reg, box_h_reg;
    logic [PCOUNT_W-1:0] pcount_reg;

    cfg_t       cfg;
    in_item_t   in_item;
    out_item_t  out_item;

    logic       part_we;
    logic [IDX_W-1:0] part_waddr, part_raddr;
    part_ent_t  part_wdata, part_rdata;
    logic       pend_we;
    logic [IDX_W-1:0] pend_waddr, pend_raddr;
    pend_ent_t  pend_wdata, pend_rdata;

    // hold the registers; each write takes the low bits of the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_w_reg <= FRAME_W'(640);
            frame_h_reg <= FRAME_W'(480);
            box_w_reg   <= BOX_W'(32);
            box_h_reg   <= BOX_W'(32);
            pcount_reg  <= PCOUNT_W'(64);
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_FRAME_WIDTH:    frame_w_reg <= cfg_wdata[FRAME_W-1:0];
                CFG_FRAME_HEIGHT:   frame_h_reg <= cfg_wdata[FRAME_W-1:0];
                CFG_BOX_WIDTH:      box_w_reg   <= cfg_wdata[BOX_W-1:0];
                CFG_BOX_HEIGHT:     box_h_reg   <= cfg_wdata[BOX_W-1:0];
                CFG_PARTICLE_COUNT: pcount_reg  <= cfg_wdata[PCOUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // clamp the particle count: zero acts as one, anything above the table size as full
    always_comb begin
        cfg.frame_w = frame_w_reg;
        cfg.frame_h = frame_h_reg;
        cfg.box_w   = box_w_reg;
        cfg.box_h   = box_h_reg;
        if (pcount_reg == '0) begin
            cfg.count = CNT_W'(1);
        end else if (CNT_W'(pcount_reg) > CNT_W'(MAX_PARTICLES)) begin
            cfg.count = CNT_W'(MAX_PARTICLES);
        end else begin
            cfg.count = CNT_W'(pcount_reg);
        end
    end

    // unpack the input word
    assign in_item.op       = s_tuser;
    assign in_item.slot     = s_tdata[5:0];
    assign in_item.pos_x    = s_tdata[17:6];
    assign in_item.pos_y    = s_tdata[29:18];
    assign in_item.score    = s_tdata[45:30];
    assign in_item.draw     = s_tdata[52:46];
    assign in_item.jitter_x = s_tdata[58:53];
    assign in_item.jitter_y = s_tdata[64:59];

    // pack the result word
    assign m_tdata = {2'b00, out_item.new_y, out_item.new_x, out_item.chosen};
    assign m_tlast = out_item.round_done;

    prj_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_item   (out_item),
        .part_we    (part_we),
        .part_waddr (part_waddr),
        .part_wdata (part_wdata),
        .part_raddr (part_raddr),
        .part_rdata (part_rdata),
        .pend_we    (pend_we),
        .pend_waddr (pend_waddr),
        .pend_wdata (pend_wdata),
        .pend_raddr (pend_raddr),
        .pend_rdata (pend_rdata)
    );

    // particle table: x, y and weight per slot
    prj_ram #(
        .WIDTH (PART_W),
        .DEPTH (MAX_PARTICLES)
    ) u_part_ram (
        .aclk  (aclk),
        .we    (part_we),
        .waddr (part_waddr),
        .wdata (part_wdata),
        .raddr (part_raddr),
        .rdata (part_rdata)
    );

    // coordinates of the round in progress, one entry per draw
    prj_ram #(
        .WIDTH (PEND_W),
        .DEPTH (MAX_PARTICLES)
    ) u_pend_ram (
        .aclk  (aclk),
        .we    (pend_we),
        .waddr (pend_waddr),
        .wdata (pend_wdata),
        .raddr (pend_raddr),
        .rdata (pend_rdata)
    );

endmodule
`default_nettype wire

// ----- rtl/prj_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module prj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/prj_core.sv -----
// Resampling sequencer: load, roulette walk, jitter and commit sweep.
`timescale 1ns / 1ps
`default_nettype none
module prj_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire prj_pkg::cfg_t                cfg,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire prj_pkg::in_item_t            in_item,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output prj_pkg::out_item_t                out_item,
    // particle table
    output logic                              part_we,
    output logic [prj_pkg::IDX_W-1:0]         part_waddr,
    output prj_pkg::part_ent_t                part_wdata,
    output logic [prj_pkg::IDX_W-1:0]         part_raddr,
    input  wire prj_pkg::part_ent_t           part_rdata,
    // pending coordinates
    output logic                              pend_we,
    output logic [prj_pkg::IDX_W-1:0]         pend_waddr,
    output prj_pkg::pend_ent_t                pend_wdata,
    output logic [prj_pkg::IDX_W-1:0]         pend_raddr,
    input  wire prj_pkg::pend_ent_t           pend_rdata
);
    import prj_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_FIN    = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [TOTAL_W-1:0]      total_reg, total_next;
    logic [CNT_W-1:0]        dc_reg, dc_next;
    logic [CNT_W-1:0]        ptr_reg, ptr_next;
    logic                    dvld_reg, dvld_next;
    logic [IDX_W-1:0]        didx_reg, didx_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [ACC_W-1:0]        target_reg, target_next;
    logic signed [JIT_W-1:0] jx_reg, jx_next, jy_reg, jy_next;
    logic [COORD_W-1:0]      x0_reg, x0_next, y0_reg, y0_next;
    logic [COORD_W-1:0]      bx_reg, bx_next, by_reg, by_next;
    logic [IDX_W-1:0]        pick_reg, pick_next;
    logic                    mv_reg, mv_next;
    out_item_t               mo_reg, mo_next;

    logic               accept;
    logic [ACC_W-1:0]   acc_sum;
    logic [CNT_W-1:0]   count_m1;
    logic               at_last;
    logic [TOTAL_W:0]   load_sum;
    logic [COORD_W-1:0] nx, ny;
    logic [CNT_W-1:0]   dc_inc;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = mv_reg;
    assign out_item  = mo_reg;

    assign acc_sum  = acc_reg + ACC_W'(part_rdata.weight) * ACC_W'(PCT);
    assign count_m1 = cfg.count - CNT_W'(1);
    assign at_last  = ({1'b0, didx_reg} == count_m1);
    assign load_sum = (TOTAL_W + 1)'(total_reg) + (TOTAL_W + 1)'(in_item.score);
    assign nx       = jit_coord(bx_reg, jx_reg, cfg.frame_w, cfg.box_w);
    assign ny       = jit_coord(by_reg, jy_reg, cfg.frame_h, cfg.box_h);
    assign dc_inc   = dc_reg + CNT_W'(1);

    assign part_raddr = (state_reg == ST_IDLE) ? '0 : ptr_reg[IDX_W-1:0];
    assign pend_raddr = ptr_reg[IDX_W-1:0];
    assign pend_waddr = dc_reg[IDX_W-1:0];
    assign pend_wdata = '{y: ny, x: nx};

    always_comb begin
        state_next  = state_reg;
        total_next  = total_reg;
        dc_next     = dc_reg;
        ptr_next    = ptr_reg;
        dvld_next   = 1'b0;
        didx_next   = (state_reg == ST_IDLE) ? '0 : ptr_reg[IDX_W-1:0];
        acc_next    = acc_reg;
        target_next = target_reg;
        jx_next     = jx_reg;
        jy_next     = jy_reg;
        x0_next     = x0_reg;
        y0_next     = y0_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        pick_next   = pick_reg;
        mv_next     = mv_reg && !out_ready;
        mo_next     = mo_reg;
        part_we     = 1'b0;
        part_waddr  = in_item.slot;
        part_wdata  = '{weight: in_item.score, y: in_item.pos_y, x: in_item.pos_x};
        pend_we     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && in_item.op == OP_LOAD) begin
                    if ({1'b0, in_item.slot} < CNT_W'(MAX_PARTICLES)) begin
                        part_we = 1'b1;
                        if (in_item.slot == '0) begin
                            total_next = TOTAL_W'(in_item.score);
                        end else if (load_sum[TOTAL_W]) begin
                            total_next = '1;
                        end else begin
                            total_next = load_sum[TOTAL_W-1:0];
                        end
                    end
                end else if (accept) begin
                    // entry 0 read goes out now; walk starts with its data
                    target_next = ACC_W'(in_item.draw) * ACC_W'(total_reg);
                    acc_next    = '0;
                    jx_next     = in_item.jitter_x;
                    jy_next     = in_item.jitter_y;
                    ptr_next    = CNT_W'(1);
                    state_next  = ST_WALK;
                end
            end
            ST_WALK: begin
                ptr_next = ptr_reg + CNT_W'(1);
                acc_next = acc_sum;
                if (didx_reg == '0) begin
                    x0_next = part_rdata.x;
                    y0_next = part_rdata.y;
                end
                if (acc_sum >= target_reg) begin
                    pick_next  = didx_reg;
                    bx_next    = part_rdata.x;
                    by_next    = part_rdata.y;
                    state_next = ST_FIN;
                end else if (at_last) begin
                    // no hit: fall back to entry 0
                    pick_next  = '0;
                    bx_next    = (didx_reg == '0) ? part_rdata.x : x0_reg;
                    by_next    = (didx_reg == '0) ? part_rdata.y : y0_reg;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!mv_reg || out_ready) begin
                    pend_we = 1'b1;
                    mv_next = 1'b1;
                    mo_next = '{chosen: pick_reg, new_x: nx, new_y: ny,
                                round_done: (dc_inc >= cfg.count)};
                    if (dc_inc >= cfg.count) begin
                        dc_next    = '0;
                        total_next = TOTAL_W'(cfg.count);
                        ptr_next   = '0;
                        state_next = ST_COMMIT;
                    end else begin
                        dc_next    = dc_inc;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_COMMIT: begin
                if (ptr_reg < cfg.count) begin
                    ptr_next  = ptr_reg + CNT_W'(1);
                    dvld_next = 1'b1;
                end
                if (dvld_reg) begin
                    part_we    = 1'b1;
                    part_waddr = didx_reg;
                    part_wdata = '{weight: WEIGHT_W'(1), y: pend_rdata.y, x: pend_rdata.x};
                    if (at_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            dc_reg    <= '0;
            ptr_reg   <= '0;
            dvld_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
            dc_reg    <= dc_next;
            ptr_reg   <= ptr_next;
            dvld_reg  <= dvld_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        didx_reg   <= didx_next;
        acc_reg    <= acc_next;
        target_reg <= target_next;
        jx_reg     <= jx_next;
        jy_reg     <= jy_next;
        x0_reg     <= x0_next;
        y0_reg     <= y0_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
        pick_reg   <= pick_next;
        mo_reg     <= mo_next;
    end

endmodule
`default_nettype wire

// ----- rtl/prj_chk.sv -----
// Port-level checks of the resampler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module prj_chk (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic                           s_tuser,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [prj_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic                           m_tlast
);
    import prj_pkg::*;

    // no result is left over from before reset
    a_reset_clears : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // no item gives a result in the cycle after it is taken
    a_no_early_result : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared one cycle after an accepted word");

    // a draw occupies the block: no word is taken right after it
    a_draw_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_DRAW |=> !s_tready)
        else $error("input ready right after a draw");

endmodule

bind particle_resample_jitter prj_chk u_prj_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
